// ===== src/ffha_pkg.sv =====
// ----------------------------------------------------------------------------
// ffha_pkg: shared codes and types of the first-fit heap allocator
// Command and status codes, fixed field widths and the store control bundle.
// ----------------------------------------------------------------------------
package ffha_pkg;

   localparam int GRANULE_BYTES = 16;
   localparam int NEED_W        = 21;

   localparam logic [1:0] CMD_ALLOC  = 2'd0;
   localparam logic [1:0] CMD_FREE   = 2'd1;
   localparam logic [1:0] CMD_RESIZE = 2'd2;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_NULL = 2'd1;
   localparam logic [1:0] ST_OOM  = 2'd2;
   localparam logic [1:0] ST_BAD  = 2'd3;

   typedef struct packed {
      logic meta_we;
      logic prev_we;
   } store_ctl_type;

endpackage

// ===== src/ffha_store.sv =====
// ----------------------------------------------------------------------------
// ffha_store: per-granule header store
// Two memories: {start, free, payload} and previous start, with a shared
// read address and registered read data.
// ----------------------------------------------------------------------------
module ffha_store #(
   parameter int GW = 12
) (
   input  logic                    clock,
   input  ffha_pkg::store_ctl_type ctl,
   input  logic [GW-1:0]           rd_addr,
   input  logic [GW-1:0]           meta_waddr,
   input  logic [GW+1:0]           meta_wdata,
   input  logic [GW-1:0]           prev_waddr,
   input  logic [GW-1:0]           prev_wdata,
   output logic [GW+1:0]           meta_rdata,
   output logic [GW-1:0]           prev_rdata
);

   logic [GW+1:0] meta_mem [2**GW];
   logic [GW-1:0] prev_mem [2**GW];

   always_ff @(posedge clock) begin
      if (ctl.meta_we) begin
         meta_mem[meta_waddr] <= meta_wdata;
      end
      meta_rdata <= meta_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (ctl.prev_we) begin
         prev_mem[prev_waddr] <= prev_wdata;
      end
      prev_rdata <= prev_mem[rd_addr];
   end

endmodule

// ===== src/first_fit_heap_allocator_core.sv =====
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_core: first-fit allocator with coalescing
// Walks block headers one at a time with a single shared adder.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_*): one transaction carries cmd (allocate, free,
//   resize), the requested size and a block payload offset. req_stall is low
//   only while the sequencer is idle, so one transaction is worked at a time.
//   Response channel (rsp_*): exactly one transaction per request, held in an
//   output register; a new request is taken while a response waits.
//   Reset: the header store is swept one granule per cycle over its
//   REGION_BYTES/16 granules (4096 at the default size), with req_stall high throughout.
//   Work per command: a zero size, a null free or command three goes straight
//   to the response; a misaligned offset is refused at the pointer check; a
//   pointer that fails the store check or a resize that fits in place ends
//   after the header read. Allocation walks the block headers, one memory read
//   a cycle, up to NG/(HG+1) headers (1365 at defaults), and splits the block
//   when more than HG+1 granules remain. Free merges with each neighbor that is
//   free. A moving resize adds the pointer check and the freeing of the old block.
//   The next request can be taken in the cycle after the response loads.
//   When the receiver stalls, the finished response holds in the output
//   register and the sequencer waits before overwriting it.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_core #(
   parameter int REGION_BYTES = 65536,
   parameter int HEADER_BYTES = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [23:0] req_req_size,
   input  logic [15:0] req_block_offset,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_result_offset,
   output logic [1:0]  rsp_status,
   output logic        rsp_moved,
   output logic [15:0] rsp_copy_bytes
);

   localparam int NG = REGION_BYTES / ffha_pkg::GRANULE_BYTES;
   localparam int HG = (HEADER_BYTES + ffha_pkg::GRANULE_BYTES - 1) / ffha_pkg::GRANULE_BYTES;
   localparam int GW = $clog2(NG);
   localparam int SW = GW + 2;

   typedef enum logic [16:0] {
      S_CLEAR    = 17'h00001,
      S_IDLE     = 17'h00002,
      S_CHECK    = 17'h00004,
      S_CHECK_W  = 17'h00008,
      S_SRCH     = 17'h00010,
      S_SRCH_W   = 17'h00020,
      S_SPLIT_A  = 17'h00040,
      S_SPLIT_B  = 17'h00080,
      S_FREE_RD  = 17'h00100,
      S_FREE_W   = 17'h00200,
      S_NEXT_W   = 17'h00400,
      S_NEXT_B   = 17'h00800,
      S_PREV_CHK = 17'h01000,
      S_PREV_W   = 17'h02000,
      S_PREV_B   = 17'h04000,
      S_FREE_SET = 17'h08000,
      S_DONE     = 17'h10000
   } state_type;

   // Payload offset of the block whose header starts at granule s.
   function automatic logic [15:0] off_of(input logic [GW-1:0] s);
      logic [31:0] t;
      t = 32'(s) + 32'(HG);
      return {t[11:0], 4'b0000};
   endfunction

   state_type state_ff, state_in;
   logic [GW-1:0] clr_ff, clr_in;
   logic [1:0]  cmd_ff, cmd_in;
   logic [23:0] req_ff, req_in;
   logic [15:0] off_ff, off_in;
   logic [ffha_pkg::NEED_W-1:0] need_ff, need_in;
   logic [GW-1:0] blk_ff, blk_in;
   logic [GW-1:0] s_ff, s_in;
   logic [GW-1:0] oldp_ff, oldp_in;
   logic [GW-1:0] pay_ff, pay_in;
   logic [GW-1:0] q_ff, q_in;
   logic [GW-1:0] remhg_ff, remhg_in;
   logic [GW-1:0] nb_ff, nb_in;
   logic [SW-1:0] n_ff, n_in;
   logic [SW-1:0] after_ff, after_in;
   logic          mvp_ff, mvp_in;
   logic [15:0]   res_ff, res_in;
   logic [1:0]    st_ff, st_in;
   logic          mv_ff, mv_in;
   logic [15:0]   cp_ff, cp_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [15:0]   rsp_off_ff, rsp_off_in;
   logic [1:0]    rsp_st_ff, rsp_st_in;
   logic          rsp_mv_ff, rsp_mv_in;
   logic [15:0]   rsp_cp_ff, rsp_cp_in;

   // Store ports
   ffha_pkg::store_ctl_type ctl;
   logic [GW-1:0] rd_addr, meta_waddr, prev_waddr, prev_wdata;
   logic [GW+1:0] meta_wdata, meta_rdata;
   logic [GW-1:0] prev_rdata;
   logic          rd_start, rd_free;
   logic [GW-1:0] rd_pay;

   // Shared adder: a + HG + b
   logic [GW-1:0] add_a, add_b;
   logic [SW-1:0] sum;

   // Pointer check terms
   logic [11:0]   g12, gsub;
   logic          g_ok;
   logic [GW-1:0] gidx;

   logic [GW-1:0] rem;
   logic          fit;
   logic          accept;

   assign rd_start = meta_rdata[GW+1];
   assign rd_free  = meta_rdata[GW];
   assign rd_pay   = meta_rdata[GW-1:0];
   assign sum = SW'(add_a) + SW'(add_b) + SW'(HG);

   assign g12  = off_ff[15:4];
   assign gsub = g12 - 12'(HG);
   assign g_ok = (off_ff[3:0] == 4'd0) && (32'(g12) >= 32'(HG)) && (32'(gsub) < 32'(NG));
   assign gidx = GW'(gsub);

   assign fit = rd_free && (32'(rd_pay) >= 32'(need_ff));
   assign rem = rd_pay - GW'(need_ff);

   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);

   ffha_store #(.GW(GW)) u_store (
      .clock      (clock),
      .ctl        (ctl),
      .rd_addr    (rd_addr),
      .meta_waddr (meta_waddr),
      .meta_wdata (meta_wdata),
      .prev_waddr (prev_waddr),
      .prev_wdata (prev_wdata),
      .meta_rdata (meta_rdata),
      .prev_rdata (prev_rdata)
   );

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      cmd_in = cmd_ff;
      req_in = req_ff;
      off_in = off_ff;
      need_in = need_ff;
      blk_in = blk_ff;
      s_in = s_ff;
      oldp_in = oldp_ff;
      pay_in = pay_ff;
      q_in = q_ff;
      remhg_in = remhg_ff;
      nb_in = nb_ff;
      n_in = n_ff;
      after_in = after_ff;
      mvp_in = mvp_ff;
      res_in = res_ff;
      st_in = st_ff;
      mv_in = mv_ff;
      cp_in = cp_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_off_in = rsp_off_ff;
      rsp_st_in = rsp_st_ff;
      rsp_mv_in = rsp_mv_ff;
      rsp_cp_in = rsp_cp_ff;
      ctl = '0;
      rd_addr = s_ff;
      meta_waddr = s_ff;
      meta_wdata = '0;
      prev_waddr = s_ff;
      prev_wdata = '0;
      add_a = s_ff;
      add_b = rd_pay;

      // Drop the response once the receiver takes it.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            // Sweep the store back to one free block spanning the region.
            ctl.meta_we = 1'b1;
            ctl.prev_we = 1'b1;
            meta_waddr = clr_ff;
            prev_waddr = clr_ff;
            if (clr_ff == '0) begin
               meta_wdata = {1'b1, 1'b1, GW'(NG - HG)};
            end
            clr_in = clr_ff + 1'b1;
            if (32'(clr_ff) == NG - 1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cmd_in = req_cmd;
               req_in = req_req_size;
               off_in = req_block_offset;
               need_in = ffha_pkg::NEED_W'((25'(req_req_size) + 25'd15) >> 4);
               res_in = '0;
               st_in = ffha_pkg::ST_OK;
               mv_in = 1'b0;
               cp_in = '0;
               mvp_in = 1'b0;
               s_in = '0;
               if (req_cmd == ffha_pkg::CMD_ALLOC ||
                   (req_cmd == ffha_pkg::CMD_RESIZE && req_block_offset == 16'd0)) begin
                  if (req_req_size == 24'd0) begin
                     st_in = ffha_pkg::ST_NULL;
                     state_in = S_DONE;
                  end else begin
                     state_in = S_SRCH;
                  end
               end else if (req_cmd == ffha_pkg::CMD_FREE) begin
                  state_in = (req_block_offset == 16'd0) ? S_DONE : S_CHECK;
               end else if (req_cmd == ffha_pkg::CMD_RESIZE) begin
                  state_in = S_CHECK;
               end else begin
                  st_in = ffha_pkg::ST_NULL;
                  state_in = S_DONE;
               end
            end
         end
         S_CHECK: begin
            rd_addr = gidx;
            blk_in = gidx;
            if (g_ok) begin
               state_in = S_CHECK_W;
            end else begin
               st_in = ffha_pkg::ST_BAD;
               state_in = S_DONE;
            end
         end
         S_CHECK_W: begin
            if (!rd_start || rd_free) begin
               st_in = ffha_pkg::ST_BAD;
               state_in = S_DONE;
            end else if (cmd_ff == ffha_pkg::CMD_FREE) begin
               state_in = S_FREE_RD;
            end else if (req_ff == 24'd0) begin
               st_in = ffha_pkg::ST_NULL;
               state_in = S_FREE_RD;
            end else if ((32'(rd_pay) << 4) >= 32'(req_ff)) begin
               res_in = off_ff;
               state_in = S_DONE;
            end else begin
               oldp_in = rd_pay;
               mvp_in = 1'b1;
               s_in = '0;
               state_in = S_SRCH;
            end
         end
         S_SRCH: begin
            rd_addr = s_ff;
            state_in = S_SRCH_W;
         end
         S_SRCH_W: begin
            add_a = s_ff;
            add_b = rd_pay;
            if (fit) begin
               res_in = off_of(s_ff);
               if (32'(rem) > 32'(HG + 1)) begin
                  after_in = sum;
                  remhg_in = rem - GW'(HG);
                  state_in = S_SPLIT_A;
               end else begin
                  ctl.meta_we = 1'b1;
                  meta_waddr = s_ff;
                  meta_wdata = {1'b1, 1'b0, rd_pay};
                  if (mvp_ff) begin
                     mv_in = 1'b1;
                     cp_in = 16'({oldp_ff, 4'b0000});
                     state_in = S_FREE_RD;
                  end else begin
                     state_in = S_DONE;
                  end
               end
            end else if (32'(sum) >= NG) begin
               st_in = ffha_pkg::ST_OOM;
               state_in = S_DONE;
            end else begin
               // Advance to the next header and read it right away.
               s_in = GW'(sum);
               rd_addr = GW'(sum);
            end
         end
         S_SPLIT_A: begin
            add_a = s_ff;
            add_b = GW'(need_ff);
            nb_in = GW'(sum);
            ctl.meta_we = 1'b1;
            meta_waddr = GW'(sum);
            meta_wdata = {1'b1, 1'b1, remhg_ff};
            ctl.prev_we = (32'(after_ff) < NG);
            prev_waddr = GW'(after_ff);
            prev_wdata = GW'(sum);
            state_in = S_SPLIT_B;
         end
         S_SPLIT_B: begin
            ctl.meta_we = 1'b1;
            meta_waddr = s_ff;
            meta_wdata = {1'b1, 1'b0, GW'(need_ff)};
            ctl.prev_we = 1'b1;
            prev_waddr = nb_ff;
            prev_wdata = s_ff;
            if (mvp_ff) begin
               mv_in = 1'b1;
               cp_in = 16'({oldp_ff, 4'b0000});
               state_in = S_FREE_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_FREE_RD: begin
            rd_addr = blk_ff;
            state_in = S_FREE_W;
         end
         S_FREE_W: begin
            add_a = blk_ff;
            add_b = rd_pay;
            pay_in = rd_pay;
            q_in = prev_rdata;
            n_in = sum;
            rd_addr = GW'(sum);
            state_in = (32'(sum) < NG) ? S_NEXT_W : S_PREV_CHK;
         end
         S_NEXT_W: begin
            // Merge with a free next neighbor.
            add_a = pay_ff;
            add_b = rd_pay;
            if (rd_free) begin
               pay_in = GW'(sum);
               ctl.meta_we = 1'b1;
               meta_waddr = GW'(n_ff);
               meta_wdata = '0;
               state_in = S_NEXT_B;
            end else begin
               state_in = S_PREV_CHK;
            end
         end
         S_NEXT_B: begin
            add_a = blk_ff;
            add_b = pay_ff;
            n_in = sum;
            ctl.prev_we = (32'(sum) < NG);
            prev_waddr = GW'(sum);
            prev_wdata = blk_ff;
            state_in = S_PREV_CHK;
         end
         S_PREV_CHK: begin
            rd_addr = q_ff;
            state_in = (blk_ff == '0) ? S_FREE_SET : S_PREV_W;
         end
         S_PREV_W: begin
            // Merge into a free previous neighbor.
            add_a = rd_pay;
            add_b = pay_ff;
            if (rd_free) begin
               ctl.meta_we = 1'b1;
               meta_waddr = q_ff;
               meta_wdata = {1'b1, 1'b1, GW'(sum)};
               state_in = S_PREV_B;
            end else begin
               state_in = S_FREE_SET;
            end
         end
         S_PREV_B: begin
            ctl.meta_we = 1'b1;
            meta_waddr = blk_ff;
            meta_wdata = '0;
            ctl.prev_we = (32'(n_ff) < NG);
            prev_waddr = GW'(n_ff);
            prev_wdata = q_ff;
            state_in = S_DONE;
         end
         S_FREE_SET: begin
            ctl.meta_we = 1'b1;
            meta_waddr = blk_ff;
            meta_wdata = {1'b1, 1'b1, pay_ff};
            state_in = S_DONE;
         end
         S_DONE: begin
            // Hold until the output register is free.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_off_in = res_ff;
               rsp_st_in = st_ff;
               rsp_mv_in = mv_ff;
               rsp_cp_in = cp_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      req_ff <= req_in;
      off_ff <= off_in;
      need_ff <= need_in;
      blk_ff <= blk_in;
      s_ff <= s_in;
      oldp_ff <= oldp_in;
      pay_ff <= pay_in;
      q_ff <= q_in;
      remhg_ff <= remhg_in;
      nb_ff <= nb_in;
      n_ff <= n_in;
      after_ff <= after_in;
      mvp_ff <= mvp_in;
      res_ff <= res_in;
      st_ff <= st_in;
      mv_ff <= mv_in;
      cp_ff <= cp_in;
      rsp_off_ff <= rsp_off_in;
      rsp_st_ff <= rsp_st_in;
      rsp_mv_ff <= rsp_mv_in;
      rsp_cp_ff <= rsp_cp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_result_offset = rsp_off_ff;
   assign rsp_status = rsp_st_ff;
   assign rsp_moved = rsp_mv_ff;
   assign rsp_copy_bytes = rsp_cp_ff;

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("request taken while busy");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("response raised outside done");

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> req_stall)
      else $error("request open during clearing");

   a_moved_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_mv_ff) |-> (rsp_st_ff == ffha_pkg::ST_OK && rsp_off_ff != 16'd0))
      else $error("moved response without a block");
`endif

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for first_fit_heap_allocator_core
// Drives allocate, free and resize transactions through the request channel,
// keeps its own model of the block header store to predict every response,
// and compares each response field by field as it leaves the response channel.
// ----------------------------------------------------------------------------
module testbench;

   localparam int HDR_G  = 2;      // header granules (32 bytes)
   localparam int NUM_G  = 4096;   // granules in the 64 KiB region
   localparam logic [1:0] CMD_NONE = 2'd3;

   typedef struct packed {
      logic [15:0] offset;
      logic [1:0]  status;
      logic        moved;
      logic [15:0] copy;
   } heap_rsp_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_cmd;
   logic [23:0] req_req_size;
   logic [15:0] req_block_offset;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [15:0] rsp_result_offset;
   logic [1:0]  rsp_status;
   logic        rsp_moved;
   logic [15:0] rsp_copy_bytes;

   // Header store as the allocator should see it.
   bit          blk_start [NUM_G];
   bit          blk_free  [NUM_G];
   logic [11:0] blk_pay   [NUM_G];
   logic [11:0] blk_prev  [NUM_G];

   heap_rsp_type pending_rsps[$];
   int error_count = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;

   first_fit_heap_allocator_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_req_size      (req_req_size),
      .req_block_offset  (req_block_offset),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_offset (rsp_result_offset),
      .rsp_status        (rsp_status),
      .rsp_moved         (rsp_moved),
      .rsp_copy_bytes    (rsp_copy_bytes)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop well past the slowest correct run, reset sweep included.
   initial begin
      #80_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // ---------------------------------------------------------------- model --
   function automatic int next_block(int s);
      return s + HDR_G + int'(blk_pay[s]);
   endfunction

   function automatic void heap_clear();
      for (int g = 0; g < NUM_G; g++) begin
         blk_start[g] = 0;
         blk_free[g]  = 0;
         blk_pay[g]   = '0;
         blk_prev[g]  = '0;
      end
      blk_start[0] = 1;
      blk_free[0]  = 1;
      blk_pay[0]   = 12'(NUM_G - HDR_G);
   endfunction

   // First fit; returns the block start granule or NUM_G when nothing fits.
   function automatic int first_fit(int unsigned nbytes);
      int unsigned need;
      int unsigned spare;
      int s;
      int nb;
      int after;
      need = (nbytes + 15) >> 4;
      s = 0;
      while (s < NUM_G) begin
         if (blk_free[s] && blk_pay[s] >= need) begin
            spare = blk_pay[s] - need;
            if (spare * 16 > HDR_G * 16 + 16) begin
               nb = s + HDR_G + need;
               after = next_block(s);
               blk_start[nb] = 1;
               blk_free[nb]  = 1;
               blk_pay[nb]   = 12'(spare - HDR_G);
               blk_prev[nb]  = 12'(s);
               if (after < NUM_G) blk_prev[after] = 12'(nb);
               blk_pay[s] = 12'(need);
            end
            blk_free[s] = 0;
            return s;
         end
         s = next_block(s);
      end
      return NUM_G;
   endfunction

   // Release a block, merging the next neighbor, then the previous one.
   function automatic void release_block(int s);
      int n;
      int nn;
      int q;
      n = next_block(s);
      blk_free[s] = 1;
      if (n < NUM_G && blk_free[n]) begin
         nn = next_block(n);
         blk_pay[s] = blk_pay[s] + 12'(HDR_G) + blk_pay[n];
         blk_start[n] = 0;
         blk_free[n]  = 0;
         if (nn < NUM_G) blk_prev[nn] = 12'(s);
      end
      if (s != 0) begin
         q = int'(blk_prev[s]);
         if (blk_free[q]) begin
            n = next_block(s);
            blk_pay[q] = blk_pay[q] + 12'(HDR_G) + blk_pay[s];
            blk_start[s] = 0;
            blk_free[s]  = 0;
            if (n < NUM_G) blk_prev[n] = 12'(q);
         end
      end
   endfunction

   // Start granule of a live block named by a payload offset, else NUM_G.
   function automatic int live_block(logic [15:0] off);
      int g;
      if (off[3:0] != 4'd0) return NUM_G;
      g = int'(off[15:4]);
      if (g < HDR_G) return NUM_G;
      g -= HDR_G;
      if (!blk_start[g] || blk_free[g]) return NUM_G;
      return g;
   endfunction

   function automatic logic [15:0] payload_offset(int s);
      return 16'((s + HDR_G) * 16);
   endfunction

   function automatic heap_rsp_type heap_predict(logic [1:0] cmd, logic [23:0] nbytes,
                                                 logic [15:0] off);
      heap_rsp_type r;
      int s;
      int b;
      int old_pay;
      r = '0;
      r.status = ffha_pkg::ST_OK;
      if (cmd == ffha_pkg::CMD_ALLOC || (cmd == ffha_pkg::CMD_RESIZE && off == 16'd0)) begin
         if (nbytes == 24'd0) begin
            r.status = ffha_pkg::ST_NULL;
         end else begin
            s = first_fit(nbytes);
            if (s >= NUM_G) r.status = ffha_pkg::ST_OOM;
            else r.offset = payload_offset(s);
         end
      end else if (cmd == ffha_pkg::CMD_FREE) begin
         if (off != 16'd0) begin
            b = live_block(off);
            if (b >= NUM_G) r.status = ffha_pkg::ST_BAD;
            else release_block(b);
         end
      end else if (cmd == ffha_pkg::CMD_RESIZE) begin
         b = live_block(off);
         if (b >= NUM_G) begin
            r.status = ffha_pkg::ST_BAD;
         end else if (nbytes == 24'd0) begin
            release_block(b);
            r.status = ffha_pkg::ST_NULL;
         end else if (int'(blk_pay[b]) * 16 >= int'(nbytes)) begin
            r.offset = off;
         end else begin
            old_pay = int'(blk_pay[b]);
            s = first_fit(nbytes);
            if (s >= NUM_G) begin
               r.status = ffha_pkg::ST_OOM;
            end else begin
               r.offset = payload_offset(s);
               r.moved  = 1'b1;
               r.copy   = 16'(old_pay * 16);
               release_block(b);
            end
         end
      end else begin
         r.status = ffha_pkg::ST_NULL;
      end
      return r;
   endfunction

   // Random live payload offset, or null when nothing is allocated.
   function automatic logic [15:0] pick_live();
      logic [15:0] live[$];
      for (int g = 0; g < NUM_G; g++)
         if (blk_start[g] && !blk_free[g]) live.push_back(payload_offset(g));
      if (live.size() == 0) return 16'd0;
      return live[$urandom_range(live.size() - 1)];
   endfunction

   // -------------------------------------------------------------- driving --
   // Present one transaction, hold it until accepted, then log its response.
   task automatic send_item(logic [1:0] cmd, logic [23:0] nbytes, logic [15:0] off);
      int gap;
      gap = 0;
      if (send_idle_pct > 0)
         while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_cmd          <= cmd;
      req_req_size     <= nbytes;
      req_block_offset <= off;
      do @(posedge clock); while (req_stall);
      pending_rsps.push_back(heap_predict(cmd, nbytes, off));
   endtask

   task automatic idle_request();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Receiver back-pressure, redrawn every cycle.
   always @(posedge clock) begin
      rsp_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
   end

   // ------------------------------------------------------------- checking --
   task automatic report_mismatch(string field, int got, int want);
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      heap_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsps.size() == 0) begin
            report_mismatch("responses outstanding", 1, 0);
         end else begin
            want = pending_rsps.pop_front();
            if (rsp_result_offset !== want.offset)
               report_mismatch("result_offset", rsp_result_offset, want.offset);
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_moved !== want.moved)
               report_mismatch("moved", rsp_moved, want.moved);
            if (rsp_copy_bytes !== want.copy)
               report_mismatch("copy_bytes", rsp_copy_bytes, want.copy);
         end
      end
   end

   // ---------------------------------------------------------------- tests --
   // Zero size, no fit, smallest and exact-remainder allocations.
   task automatic test_alloc_edges();
      send_item(ffha_pkg::CMD_ALLOC, 24'd0, 16'd0);
      send_item(ffha_pkg::CMD_ALLOC, 24'hFFFFFF, 16'hFFFF);
      send_item(ffha_pkg::CMD_ALLOC, 24'd1, 16'd0);
      send_item(ffha_pkg::CMD_ALLOC, 24'd16, 16'd0);
      send_item(ffha_pkg::CMD_ALLOC, 24'd17, 16'd0);
      send_item(CMD_NONE, 24'hFFFFFF, 16'hFFFF);
   endtask

   // Null, misaligned, before-first-payload, non-start and double frees,
   // then a free that merges with the previous block.
   task automatic test_free_cases();
      send_item(ffha_pkg::CMD_FREE, 24'd0, 16'd0);
      send_item(ffha_pkg::CMD_FREE, 24'd0, 16'd40);
      send_item(ffha_pkg::CMD_FREE, 24'd0, 16'd16);
      send_item(ffha_pkg::CMD_FREE, 24'd0, 16'd48);
      send_item(ffha_pkg::CMD_FREE, 24'hFFFFFF, 16'd32);     // first block, goes free
      send_item(ffha_pkg::CMD_FREE, 24'd0, 16'd32);          // now a free block
      send_item(ffha_pkg::CMD_FREE, 24'd0, 16'd112);         // not a block start, refused
      send_item(ffha_pkg::CMD_FREE, 24'd0, 16'd80);          // middle, merges the previous block
   endtask

   // Null, moving, misaligned and bad pointer resizes.
   task automatic test_resize_cases();
      send_item(ffha_pkg::CMD_RESIZE, 24'd100, 16'd0);       // acts as allocate at 192
      send_item(ffha_pkg::CMD_RESIZE, 24'd112, 16'd32);      // free block, refused
      send_item(ffha_pkg::CMD_ALLOC, 24'd64, 16'd0);         // takes the free block at 32
      send_item(ffha_pkg::CMD_RESIZE, 24'd500, 16'd32);      // moves
      send_item(ffha_pkg::CMD_RESIZE, 24'hFFFFFF, 16'd176);  // not a block start, refused
      send_item(ffha_pkg::CMD_RESIZE, 24'd10, 16'd8);        // misaligned
      send_item(ffha_pkg::CMD_RESIZE, 24'd0, 16'd176);       // not a block start, refused
      send_item(ffha_pkg::CMD_RESIZE, 24'd10, 16'd176);      // still a bad pointer
   endtask

   // Mostly well-formed traffic on live blocks, with some noise.
   task automatic test_random_traffic(int count);
      int pick;
      logic [23:0] nbytes;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         case ($urandom_range(19))
            0:       nbytes = 24'($urandom);
            1, 2:    nbytes = 24'($urandom_range(8192, 1));
            3:       nbytes = 24'd0;
            default: nbytes = 24'($urandom_range(600, 1));
         endcase
         if (pick < 42) begin
            send_item(ffha_pkg::CMD_ALLOC, nbytes, 16'($urandom));
         end else if (pick < 72) begin
            send_item(ffha_pkg::CMD_FREE, 24'($urandom), pick_live());
         end else if (pick < 90) begin
            send_item(ffha_pkg::CMD_RESIZE, nbytes, pick_live());
         end else begin
            send_item(2'($urandom_range(3)), 24'($urandom), 16'($urandom));
         end
         if ($urandom_range(15) == 0) idle_request();
      end
   endtask

   initial begin
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_cmd          <= ffha_pkg::CMD_ALLOC;
      req_req_size     <= '0;
      req_block_offset <= '0;
      rsp_stall        <= 1'b0;
      heap_clear();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_alloc_edges();
      test_free_cases();
      idle_request();
      test_resize_cases();

      // Sweep the idling mixes: none, sender, receiver, both.
      send_idle_pct = 0;  stall_pct = 0;
      test_random_traffic(290);
      send_idle_pct = 64; stall_pct = 0;
      test_random_traffic(290);
      send_idle_pct = 0;  stall_pct = 64;
      test_random_traffic(290);
      send_idle_pct = 7;  stall_pct = 7;
      test_random_traffic(290);
      req_valid <= 1'b0;

      // Drain outstanding responses, then allow a short settle window.
      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== first_fit_heap_allocator_core.f =====
src/ffha_pkg.sv
src/ffha_store.sv
src/first_fit_heap_allocator_core.sv
bench/testbench.sv
